@@ rtl/rv32ic_instruction_decoder_assert.svh @@
// assertion macros for the rv32ic decoder
// used by the top level only
`ifndef RV32IC_INSTRUCTION_DECODER_ASSERT_SVH
`define RV32IC_INSTRUCTION_DECODER_ASSERT_SVH

// a condition holds at every edge out of reset
`define RVD_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define RVD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/rvd_pkg.sv @@
// types, codes and field structs of the rv32ic decoder
// no dependencies
`default_nettype none
package rvd_pkg;

  typedef enum logic [6:0] {
    K_UNK, K_ADD, K_SUB, K_SLL, K_SLT, K_SLTU, K_XOR, K_SRL, K_SRA, K_OR, K_AND,
    K_ADDI, K_SLLI, K_SLTI, K_SLTIU, K_XORI, K_SRLI, K_SRAI, K_ORI, K_ANDI,
    K_FENCE, K_FENCEI, K_ECALL, K_EBREAK,
    K_CSRRW, K_CSRRS, K_CSRRC, K_CSRRWI, K_CSRRSI, K_CSRRCI,
    K_JAL, K_LB, K_LH, K_LW, K_LBU, K_LHU, K_JALR,
    K_BEQ, K_BNE, K_BLT, K_BGE, K_BLTU, K_BGEU, K_LUI, K_AUIPC, K_SB, K_SH, K_SW,
    K_CADDI4SPN, K_CLW, K_CSW, K_CNOP, K_CADDI, K_CJAL, K_CLI, K_CADDI16SP, K_CLUI,
    K_CSRLI, K_CSRAI, K_CANDI, K_CSUB, K_CXOR, K_COR, K_CAND, K_CJ, K_CBEQZ, K_CBNEZ,
    K_CSLLI, K_CLWSP, K_CJR, K_CMV, K_CEBREAK, K_CADD, K_CJALR, K_CSWSP
  } inst_code_t;

  // major opcodes
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_FENCE  = 7'h0F;
  localparam logic [6:0] OP_SYSTEM = 7'h73;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] F7_ALT    = 7'h20;

  localparam logic [4:0] REG_RA = 5'd1;
  localparam logic [4:0] REG_SP = 5'd2;

  // decoded fields of one item, before address arithmetic
  typedef struct packed {
    inst_code_t  code;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm;
    logic [11:0] csr;
    logic        tgt;
  } dec_t;

  // result item
  typedef struct packed {
    logic [31:0] inst_addr;
    logic [6:0]  inst_code;
    logic        is_compressed;
    logic [4:0]  dest_reg;
    logic [4:0]  src1_reg;
    logic [4:0]  src2_reg;
    logic signed [31:0] immediate;
    logic [11:0] csr_number;
    logic        has_target;
    logic [31:0] target_addr;
    logic [15:0] label_number;
  } result_t;

endpackage
`default_nettype wire

@@ rtl/rvd_if.sv @@
// valid/ready channel interfaces of the rv32ic decoder
// depends on rvd_pkg
`default_nettype none
interface rvd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] inst_word;
  modport source (output valid, output inst_word, input ready);
  modport sink (input valid, input inst_word, output ready);
endinterface

interface rvd_out_if
  import rvd_pkg::*;
;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/rv32ic_instruction_decoder.sv @@
// RV32I/RV32C decoder: top level with address and label tracking
// depends on rvd_pkg, rvd_if, rvd_decode and the assertion macro header
//
// Usage:
//   in  channel (rvd_in_if, sink): one fetched word per item in inst_word;
//       a compressed instruction uses bits 15:0 only.
//   out channel (rvd_out_if, source): one result item per input item,
//       carrying address, code, registers, immediate, csr and target fields.
// Latency: an item accepted at one edge is presented on out the next cycle.
// Throughput: one item per cycle; the input word is decoded and added to the
//   tracked address by combinational logic, and the result is captured in
//   the result register at the accepting edge. in.ready is high while the
//   result register is empty or taken in the same cycle.
// Stall: while out.valid is high and out.ready low the result holds and
//   in.ready is low, so no item is lost.
// Reset (rst_n low, synchronous): result register emptied, instruction
//   address set to 0, label counter to 1.
// Each item advances the address by 2 or 4; each pc-relative jump or branch
//   (not jalr, c.jr, c.jalr) takes the next label number, stopping at 65535.
`default_nettype none
`include "rv32ic_instruction_decoder_assert.svh"
module rv32ic_instruction_decoder
  import rvd_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  rvd_in_if.sink   in_ch,
  rvd_out_if.source out_ch
);

  logic        out_valid_r;
  result_t     out_data_r, out_data_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [15:0] label_r, label_nxt;
  logic        accept;
  dec_t        dec;
  logic        comp;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  rvd_decode u_dec (
    .word (in_ch.inst_word),
    .dec  (dec)
  );

  // result item and tracked state
  always_comb begin
    comp = (in_ch.inst_word[1:0] != 2'b11);
    out_data_nxt.inst_addr     = addr_r;
    out_data_nxt.inst_code     = dec.code;
    out_data_nxt.is_compressed = comp;
    out_data_nxt.dest_reg      = dec.rd;
    out_data_nxt.src1_reg      = dec.rs1;
    out_data_nxt.src2_reg      = dec.rs2;
    out_data_nxt.immediate     = dec.imm;
    out_data_nxt.csr_number    = dec.csr;
    out_data_nxt.has_target    = dec.tgt;
    out_data_nxt.target_addr   = dec.tgt ? addr_r + dec.imm : 32'd0;
    out_data_nxt.label_number  = dec.tgt ? label_r : 16'd0;
    addr_nxt  = addr_r + (comp ? 32'd2 : 32'd4);
    label_nxt = (dec.tgt && label_r != 16'hFFFF) ? label_r + 16'd1 : label_r;
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      addr_r      <= 32'd0;
      label_r     <= 16'd1;
    end else begin
      if (accept) begin
        out_valid_r <= 1'b1;
        addr_r      <= addr_nxt;
        label_r     <= label_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (accept) out_data_r <= out_data_nxt;
  end

  `RVD_ASSERT_ALWAYS(a_label_nonzero, label_r != 16'd0, "label counter reached zero")
  `RVD_ASSERT_NEXT(a_addr_step, accept, addr_r == $past(addr_r) + ($past(comp) ? 32'd2 : 32'd4), "address step")
  `RVD_ASSERT_NEXT(a_hold, out_valid_r && !out_ch.ready, out_valid_r && $stable(out_data_r), "stalled result changed")
  `RVD_ASSERT_ALWAYS(a_target_label, !out_valid_r || (out_data_r.has_target == (out_data_r.label_number != 16'd0)), "label without target")

endmodule
`default_nettype wire

@@ rtl/rvd_decode.sv @@
// combinational rv32i / rv32c field decode of one instruction word
// depends on rvd_pkg
`default_nettype none
module rvd_decode
  import rvd_pkg::*;
(
  input  wire logic [31:0] word,
  output dec_t             dec
);

  dec_t d32, d16;

  // 32-bit formats
  always_comb begin
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [11:0] f12;
    logic [31:0] iimm;
    rd   = word[11:7];
    f3   = word[14:12];
    rs1  = word[19:15];
    rs2  = word[24:20];
    f7   = word[31:25];
    f12  = word[31:20];
    iimm = {{20{word[31]}}, f12};
    d32  = '0;
    case (word[6:0])
      OP_REG: begin
        case (f3)
          3'd0: d32.code = (f7 == F7_ALT) ? K_SUB : K_ADD;
          3'd1: d32.code = K_SLL;
          3'd2: d32.code = K_SLT;
          3'd3: d32.code = K_SLTU;
          3'd4: d32.code = K_XOR;
          3'd5: d32.code = (f7 == F7_ALT) ? K_SRA : K_SRL;
          3'd6: d32.code = K_OR;
          default: d32.code = K_AND;
        endcase
        d32.rd = rd; d32.rs1 = rs1; d32.rs2 = rs2;
      end
      OP_IMM: begin
        case (f3)
          3'd0: d32.code = K_ADDI;
          3'd1: d32.code = K_SLLI;
          3'd2: d32.code = K_SLTI;
          3'd3: d32.code = K_SLTIU;
          3'd4: d32.code = K_XORI;
          3'd5: d32.code = (f7 == F7_ALT) ? K_SRAI : K_SRLI;
          3'd6: d32.code = K_ORI;
          default: d32.code = K_ANDI;
        endcase
        d32.rd = rd; d32.rs1 = rs1;
        d32.imm = (f3 == 3'd1 || f3 == 3'd5) ? {27'd0, rs2} : iimm;
      end
      OP_FENCE: begin
        if (f3 == 3'd0) d32.code = K_FENCE;
        else if (f3 == 3'd1) d32.code = K_FENCEI;
      end
      OP_SYSTEM: begin
        case (f3)
          3'd0: d32.code = (f12 == 12'd1) ? K_EBREAK : K_ECALL;
          3'd4: d32.code = K_UNK;
          default: begin
            case (f3)
              3'd1: d32.code = K_CSRRW;
              3'd2: d32.code = K_CSRRS;
              3'd3: d32.code = K_CSRRC;
              3'd5: d32.code = K_CSRRWI;
              3'd6: d32.code = K_CSRRSI;
              default: d32.code = K_CSRRCI;
            endcase
            d32.rd = rd; d32.csr = f12;
            if (!f3[2]) d32.rs1 = rs1;
            else d32.imm = {27'd0, rs1};
          end
        endcase
      end
      OP_JAL: begin
        d32.code = K_JAL; d32.rd = rd; d32.tgt = 1'b1;
        d32.imm = {{12{word[31]}}, word[19:12], word[20], word[30:21], 1'b0};
      end
      OP_LOAD: begin
        case (f3)
          3'd0: d32.code = K_LB;
          3'd1: d32.code = K_LH;
          3'd2: d32.code = K_LW;
          3'd4: d32.code = K_LBU;
          3'd5: d32.code = K_LHU;
          default: d32.code = K_UNK;
        endcase
        d32.rd = rd; d32.rs1 = rs1; d32.imm = iimm;
      end
      OP_JALR: begin
        d32.code = K_JALR; d32.rd = rd; d32.rs1 = rs1; d32.imm = iimm;
      end
      OP_BRANCH: begin
        case (f3)
          3'd0: d32.code = K_BEQ;
          3'd1: d32.code = K_BNE;
          3'd4: d32.code = K_BLT;
          3'd5: d32.code = K_BGE;
          3'd6: d32.code = K_BLTU;
          3'd7: d32.code = K_BGEU;
          default: d32.code = K_UNK;
        endcase
        d32.rs1 = rs1; d32.rs2 = rs2; d32.tgt = 1'b1;
        d32.imm = {{20{word[31]}}, word[7], word[30:25], word[11:8], 1'b0};
      end
      OP_LUI: begin
        d32.code = K_LUI; d32.rd = rd; d32.imm = {12'd0, word[31:12]};
      end
      OP_AUIPC: begin
        d32.code = K_AUIPC; d32.rd = rd; d32.imm = {12'd0, word[31:12]};
      end
      OP_STORE: begin
        case (f3)
          3'd0: d32.code = K_SB;
          3'd1: d32.code = K_SH;
          3'd2: d32.code = K_SW;
          default: d32.code = K_UNK;
        endcase
        d32.rs1 = rs1; d32.rs2 = rs2;
        d32.imm = {{20{word[31]}}, f7, rd};
      end
      default: d32 = '0;
    endcase
  end

  // 16-bit formats
  always_comb begin
    logic [15:0] c;
    logic [4:0]  r5, s5, rp1, rp2;
    logic [31:0] ci6, cu6, lsw, cj, cb;
    c   = word[15:0];
    r5  = c[11:7];
    s5  = c[6:2];
    rp1 = {2'b01, c[9:7]};
    rp2 = {2'b01, c[4:2]};
    cu6 = {26'd0, c[12], c[6:2]};
    ci6 = {{26{c[12]}}, c[12], c[6:2]};
    lsw = {25'd0, c[5], c[12:10], c[6], 2'b00};
    cj  = {{21{c[12]}}, c[8], c[10:9], c[6], c[7], c[2], c[11], c[5:3], 1'b0};
    cb  = {{24{c[12]}}, c[6:5], c[2], c[11:10], c[4:3], 1'b0};
    d16 = '0;
    case ({c[1:0], c[15:13]})
      5'd0: begin
        d16.code = K_CADDI4SPN; d16.rd = rp2; d16.rs1 = REG_SP;
        d16.imm = {22'd0, c[10:7], c[12:11], c[5], c[6], 2'b00};
      end
      5'd2: begin
        d16.code = K_CLW; d16.rd = rp2; d16.rs1 = rp1; d16.imm = lsw;
      end
      5'd6: begin
        d16.code = K_CSW; d16.rs2 = rp2; d16.rs1 = rp1; d16.imm = lsw;
      end
      5'd8: begin
        if (r5 == 5'd0) d16.code = K_CNOP;
        else begin
          d16.code = K_CADDI; d16.rd = r5; d16.rs1 = r5; d16.imm = ci6;
        end
      end
      5'd9: begin
        d16.code = K_CJAL; d16.rd = REG_RA; d16.imm = cj; d16.tgt = 1'b1;
      end
      5'd10: begin
        d16.code = K_CLI; d16.rd = r5; d16.imm = ci6;
      end
      5'd11: begin
        if (r5 == REG_SP) begin
          d16.code = K_CADDI16SP; d16.rd = REG_SP; d16.rs1 = REG_SP;
          d16.imm = {{23{c[12]}}, c[4:3], c[5], c[2], c[6], 4'd0};
        end else begin
          d16.code = K_CLUI; d16.rd = r5; d16.imm = ci6;
        end
      end
      5'd12: begin
        d16.rd = rp1; d16.rs1 = rp1;
        case (c[11:10])
          2'd0: begin d16.code = K_CSRLI; d16.imm = cu6; end
          2'd1: begin d16.code = K_CSRAI; d16.imm = cu6; end
          2'd2: begin d16.code = K_CANDI; d16.imm = ci6; end
          default: begin
            case (c[6:5])
              2'd0: d16.code = K_CSUB;
              2'd1: d16.code = K_CXOR;
              2'd2: d16.code = K_COR;
              default: d16.code = K_CAND;
            endcase
            d16.rs2 = rp2;
          end
        endcase
      end
      5'd13: begin
        d16.code = K_CJ; d16.imm = cj; d16.tgt = 1'b1;
      end
      5'd14, 5'd15: begin
        d16.code = c[13] ? K_CBNEZ : K_CBEQZ;
        d16.rs1 = rp1; d16.imm = cb; d16.tgt = 1'b1;
      end
      5'd16: begin
        d16.code = K_CSLLI; d16.rd = r5; d16.rs1 = r5; d16.imm = cu6;
      end
      5'd18: begin
        d16.code = K_CLWSP; d16.rd = r5; d16.rs1 = REG_SP;
        d16.imm = {24'd0, c[3:2], c[12], c[6:4], 2'b00};
      end
      5'd20: begin
        if (!c[12]) begin
          if (s5 == 5'd0) begin d16.code = K_CJR; d16.rs1 = r5; end
          else begin d16.code = K_CMV; d16.rd = r5; d16.rs2 = s5; end
        end else if (r5 == 5'd0 && s5 == 5'd0) begin
          d16.code = K_CEBREAK;
        end else if (r5 != 5'd0 && s5 != 5'd0) begin
          d16.code = K_CADD; d16.rd = r5; d16.rs1 = r5; d16.rs2 = s5;
        end else if (r5 != 5'd0) begin
          d16.code = K_CJALR; d16.rd = REG_RA; d16.rs1 = r5;
        end
      end
      5'd22: begin
        d16.code = K_CSWSP; d16.rs2 = s5; d16.rs1 = REG_SP;
        d16.imm = {24'd0, c[8:7], c[12:9], 2'b00};
      end
      default: d16 = '0;
    endcase
  end

  // pick by length, unknown clears all fields
  always_comb begin
    dec = (word[1:0] == 2'b11) ? d32 : d16;
    if (dec.code == K_UNK) dec = '0;
  end

endmodule
`default_nettype wire
